[src/approx_bitparallel_matcher_core_assert.svh]
// Assertion macros for the approximate matcher core.
// Included by files that check their own logic; no other dependencies.
`ifndef APPROX_BITPARALLEL_MATCHER_CORE_ASSERT_SVH
`define APPROX_BITPARALLEL_MATCHER_CORE_ASSERT_SVH
`ifndef SYNTH
`define ABM_ASSERT_IMP(label, clock, reset, pre, post) \
  label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
    else $error("abm assertion failed");
`define ABM_ASSERT_NXT(label, clock, reset, pre, post) \
  label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
    else $error("abm assertion failed");
`else
`define ABM_ASSERT_IMP(label, clock, reset, pre, post)
`define ABM_ASSERT_NXT(label, clock, reset, pre, post)
`endif
`endif

[src/abm_pkg.sv]
// Shared types and constants for the approximate matcher core.
// No dependencies.
`default_nettype none

package abm_pkg;

  localparam int unsigned PATTERN_BYTES = 32;
  localparam int unsigned LEN_W = 6;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned POS_W = 32;
  localparam logic [LEN_W-1:0] LEN_RESET = 6'd32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LEN    = 3'd0,
    REG_PATTERN_WORD_0 = 3'd1,
    REG_PATTERN_WORD_1 = 3'd2,
    REG_PATTERN_WORD_2 = 3'd3,
    REG_PATTERN_WORD_3 = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       start_text;
    logic       last_char;
  } text_item_t;

  typedef struct packed {
    logic             match_found;
    logic [POS_W-1:0] end_position;
    logic             last_out;
  } result_item_t;

  typedef struct packed {
    logic             start;
    logic             last;
    logic [POS_W-1:0] position;
  } stage_ctrl_t;

endpackage

`default_nettype wire

[src/abm_front.sv]
// Front cell: builds the character mask, keeps the exact-match row and the position.
// Depends on abm_pkg.
`default_nettype none

module abm_front #(
  parameter int W = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic [abm_pkg::LEN_W-1:0]              pattern_len,
  input  wire logic [8*abm_pkg::PATTERN_BYTES-1:0]    pattern_bits,
  input  wire logic                                   up_valid,
  output logic                                        up_ready,
  input  wire abm_pkg::text_item_t                    up_item,
  output logic                                        dn_valid,
  input  wire logic                                   dn_ready,
  output logic [W-1:0]                                dn_sel,
  output logic [W-1:0]                                dn_full,
  output logic [W-1:0]                                dn_top,
  output logic [W-1:0]                                dn_prev_old,
  output logic [W-1:0]                                dn_prev_new,
  output abm_pkg::stage_ctrl_t                        dn_ctrl
);

  localparam int MW = $clog2(W + 1);
  localparam int LW1 = abm_pkg::LEN_W + 1;

  logic [W-1:0] row;
  logic [abm_pkg::POS_W-1:0] position;

  logic [W-1:0] eq;
  logic [W-1:0] rev;
  logic [MW-1:0] m;
  logic [MW-1:0] shift;
  logic [W-1:0] full;
  logic [W-1:0] top;
  logic [W-1:0] sel;
  logic [W-1:0] old;
  logic [W-1:0] row_next;
  logic [abm_pkg::POS_W-1:0] position_next;
  logic fire;

  for (genvar i = 0; i < W; i++) begin : g_eq
    if (i < abm_pkg::PATTERN_BYTES) begin : g_byte
      assign eq[i] = (pattern_bits[8*i +: 8] == up_item.text_char);
    end else begin : g_zero
      assign eq[i] = (up_item.text_char == 8'd0);
    end
    assign rev[i] = eq[W-1-i];
  end

  always_comb begin
    if (pattern_len == '0) begin
      m = MW'(1);
    end else if ({1'b0, pattern_len} > LW1'(W)) begin
      m = MW'(W);
    end else begin
      m = MW'(pattern_len);
    end
    shift = MW'(W) - m;
    full = {W{1'b1}} >> shift;
    top = W'(1) << (m - MW'(1));
    sel = (rev >> shift) & full;
    old = up_item.start_text ? '0 : (row & full);
    row_next = ((old >> 1) | top) & sel;
    position_next = (up_item.start_text ? '0 : position) + abm_pkg::POS_W'(1);
  end

  assign up_ready = !dn_valid || dn_ready;
  assign fire = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      position <= '0;
      dn_valid <= 1'b0;
    end else begin
      if (fire) begin
        row <= row_next;
        position <= position_next;
        dn_valid <= 1'b1;
      end else if (dn_ready) begin
        dn_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      dn_sel <= sel;
      dn_full <= full;
      dn_top <= top;
      dn_prev_old <= old;
      dn_prev_new <= row_next;
      dn_ctrl.start <= up_item.start_text;
      dn_ctrl.last <= up_item.last_char;
      dn_ctrl.position <= position_next;
    end
  end

endmodule

`default_nettype wire

[src/abm_cell.sv]
// One error row of the matcher: updates its row from the row above and passes it on.
// Depends on abm_pkg.
`default_nettype none

module abm_cell #(
  parameter int W = 32,
  parameter int ROW = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 up_valid,
  output logic                      up_ready,
  input  wire logic [W-1:0]         up_sel,
  input  wire logic [W-1:0]         up_full,
  input  wire logic [W-1:0]         up_top,
  input  wire logic [W-1:0]         up_prev_old,
  input  wire logic [W-1:0]         up_prev_new,
  input  wire abm_pkg::stage_ctrl_t up_ctrl,
  output logic                      dn_valid,
  input  wire logic                 dn_ready,
  output logic [W-1:0]              dn_sel,
  output logic [W-1:0]              dn_full,
  output logic [W-1:0]              dn_top,
  output logic [W-1:0]              dn_prev_old,
  output logic [W-1:0]              dn_prev_new,
  output abm_pkg::stage_ctrl_t      dn_ctrl
);

  localparam int M0 = (W < abm_pkg::PATTERN_BYTES) ? W : abm_pkg::PATTERN_BYTES;
  localparam logic [W-1:0] FULL0 = {W{1'b1}} >> (W - M0);
  localparam logic [W-1:0] ROW_RESET = FULL0 & ~(FULL0 >> ROW);

  logic [W-1:0] row;
  logic [W-1:0] start_val;
  logic [W-1:0] old;
  logic [W-1:0] nv;
  logic fire;

  always_comb begin
    start_val = up_full & ~(up_full >> ROW);
    old = (up_ctrl.start ? start_val : row) & up_full;
    nv = (((old >> 1) & up_sel) | up_prev_old | ((up_prev_old | up_prev_new) >> 1)) & up_full;
  end

  assign up_ready = !dn_valid || dn_ready;
  assign fire = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= ROW_RESET;
      dn_valid <= 1'b0;
    end else begin
      if (fire) begin
        row <= nv | up_top;
        dn_valid <= 1'b1;
      end else if (dn_ready) begin
        dn_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      dn_sel <= up_sel;
      dn_full <= up_full;
      dn_top <= up_top;
      dn_prev_old <= old;
      dn_prev_new <= nv;
      dn_ctrl <= up_ctrl;
    end
  end

endmodule

`default_nettype wire

[src/approx_bitparallel_matcher_core.sv]
// Top level of the streaming approximate matcher: configuration registers and cell chain.
// Depends on abm_pkg, abm_front, abm_cell and the assertion macro header.
//
// Usage: text bytes arrive as requests on the text channel (text_valid, text_ready,
// text_item), one byte per request. Each request yields exactly one result request on
// the result channel (result_valid, result_ready, result_item) carrying the match flag,
// the one-based text position and the echoed last flag. A request with start_text set
// restarts the rows and the position before its byte is processed.
// The bytes flow through a chain of ERRORS+1 cells, one per error row; each cell holds
// its row and hands the previous row's old and new values to the next cell. A request
// reaches the result channel through every cell's output register in turn. One request
// is accepted every cycle until a stalled receiver has filled the chain, one request in
// each cell's output register. The user must write the pattern registers over the cfg
// channel (always ready) only while no text is in flight; the block does not enforce it.
// Reset sets the pattern length to 32, clears the pattern words and the position, empties
// the chain and loads each row with its start value.
`default_nettype none

`include "approx_bitparallel_matcher_core_assert.svh"

module approx_bitparallel_matcher_core #(
  parameter int ERRORS = 3,
  parameter int MAX_PATTERN = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               text_valid,
  output logic                                    text_ready,
  input  wire abm_pkg::text_item_t                text_item,
  output logic                                    result_valid,
  input  wire logic                               result_ready,
  output abm_pkg::result_item_t                   result_item,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [abm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [abm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [abm_pkg::LEN_W-1:0] pattern_len;
  logic [abm_pkg::CFG_DATA_W-1:0] pattern_word [4];
  logic [8*abm_pkg::PATTERN_BYTES-1:0] pattern_bits;

  logic [ERRORS:0] stage_valid;
  logic [ERRORS:0] stage_ready;
  logic [MAX_PATTERN-1:0] stage_sel [ERRORS+1];
  logic [MAX_PATTERN-1:0] stage_full [ERRORS+1];
  logic [MAX_PATTERN-1:0] stage_top [ERRORS+1];
  logic [MAX_PATTERN-1:0] stage_prev_old [ERRORS+1];
  logic [MAX_PATTERN-1:0] stage_prev_new [ERRORS+1];
  abm_pkg::stage_ctrl_t stage_ctrl [ERRORS+1];

  assign cfg_ready = 1'b1;
  assign pattern_bits = {pattern_word[3], pattern_word[2], pattern_word[1], pattern_word[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len <= abm_pkg::LEN_RESET;
      pattern_word[0] <= '0;
      pattern_word[1] <= '0;
      pattern_word[2] <= '0;
      pattern_word[3] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        abm_pkg::REG_PATTERN_LEN: begin
          pattern_len <= cfg_data[abm_pkg::LEN_W-1:0];
        end
        abm_pkg::REG_PATTERN_WORD_0: begin
          pattern_word[0] <= cfg_data;
        end
        abm_pkg::REG_PATTERN_WORD_1: begin
          pattern_word[1] <= cfg_data;
        end
        abm_pkg::REG_PATTERN_WORD_2: begin
          pattern_word[2] <= cfg_data;
        end
        abm_pkg::REG_PATTERN_WORD_3: begin
          pattern_word[3] <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  abm_front #(
    .W(MAX_PATTERN)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .pattern_len(pattern_len),
    .pattern_bits(pattern_bits),
    .up_valid(text_valid),
    .up_ready(text_ready),
    .up_item(text_item),
    .dn_valid(stage_valid[0]),
    .dn_ready(stage_ready[0]),
    .dn_sel(stage_sel[0]),
    .dn_full(stage_full[0]),
    .dn_top(stage_top[0]),
    .dn_prev_old(stage_prev_old[0]),
    .dn_prev_new(stage_prev_new[0]),
    .dn_ctrl(stage_ctrl[0])
  );

  for (genvar j = 1; j <= ERRORS; j++) begin : g_cell
    abm_cell #(
      .W(MAX_PATTERN),
      .ROW(j)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .up_valid(stage_valid[j-1]),
      .up_ready(stage_ready[j-1]),
      .up_sel(stage_sel[j-1]),
      .up_full(stage_full[j-1]),
      .up_top(stage_top[j-1]),
      .up_prev_old(stage_prev_old[j-1]),
      .up_prev_new(stage_prev_new[j-1]),
      .up_ctrl(stage_ctrl[j-1]),
      .dn_valid(stage_valid[j]),
      .dn_ready(stage_ready[j]),
      .dn_sel(stage_sel[j]),
      .dn_full(stage_full[j]),
      .dn_top(stage_top[j]),
      .dn_prev_old(stage_prev_old[j]),
      .dn_prev_new(stage_prev_new[j]),
      .dn_ctrl(stage_ctrl[j])
    );
  end

  assign stage_ready[ERRORS] = result_ready;
  assign result_valid = stage_valid[ERRORS];
  assign result_item.match_found = stage_prev_new[ERRORS][0];
  assign result_item.end_position = stage_ctrl[ERRORS].position;
  assign result_item.last_out = stage_ctrl[ERRORS].last;

  `ABM_ASSERT_NXT(a_len_write, clk, rst, cfg_valid && cfg_ready && (cfg_index == abm_pkg::REG_PATTERN_LEN), pattern_len == $past(cfg_data[abm_pkg::LEN_W-1:0]))
  `ABM_ASSERT_IMP(a_full_stall, clk, rst, result_valid && !result_ready && (&stage_valid), !text_ready)
  `ABM_ASSERT_NXT(a_start_pos, clk, rst, text_valid && text_ready && text_item.start_text, stage_valid[0] && (stage_ctrl[0].position == 32'd1))

endmodule

`default_nettype wire
